FILE: rtl/hmf_pkg.sv
package hmf_pkg;

    // Label and bin geometry
    localparam int LBL_W    = 8;
    localparam int NUM_BINS = 256;
    localparam int IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // Bin counters saturate at all ones
    localparam int               CNT_W     = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Last bin index and bin count in label width plus one
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);
    localparam logic [LBL_W:0]   BIN_LIM  = (LBL_W + 1)'(NUM_BINS);

    // Control sequence
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_COUNT,
        ST_DRAIN,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Write port of the bin memory
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } t_bin_wr;

endpackage

FILE: rtl/hmf_ram.sv
module hmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle; a same-address read sees old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/histogram_mode_finder.sv
// Channel  Direction  Handshake                 Word
// input    in         i_in_valid / o_in_stall   i_label_value, i_last_of_region
// output   out        o_out_valid / i_out_stall o_mode_value
//
// While counting, one word is taken every cycle: a forwarded read-modify-write
// on the bin memory (read, then increment and write back in the next cycle).
// A word marked last is followed by drain, a scan of every bin through the
// single read port, and finish before the next word is taken.
// After reset the bin memory is cleared one entry a cycle.
// The input stalls outside counting; the finished result waits in the output
// register; finish holds while a scan read is due or an older result stalls.
module histogram_mode_finder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [hmf_pkg::LBL_W-1:0]   i_label_value,
    input  logic                        i_last_of_region,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hmf_pkg::LBL_W-1:0]   o_mode_value
);

    hmf_pkg::t_state               r_state, n_state;
    logic [hmf_pkg::IDX_W-1:0]     r_idx, n_idx;

    // Count pipeline
    logic                          r_s1_vld;
    logic [hmf_pkg::IDX_W-1:0]     r_s1_lbl;
    logic                          r_wr_vld;
    logic [hmf_pkg::IDX_W-1:0]     r_wr_lbl;
    logic [hmf_pkg::CNT_W-1:0]     r_wr_cnt;

    // Scan pipeline
    logic                          r_sc_vld;
    logic [hmf_pkg::IDX_W-1:0]     r_sc_idx;
    logic [hmf_pkg::CNT_W-1:0]     r_best_cnt;
    logic [hmf_pkg::IDX_W-1:0]     r_best_lbl;

    // Output register
    logic                          r_out_vld;
    logic [hmf_pkg::LBL_W-1:0]     r_mode;

    logic                          in_acc;
    logic                          in_range;
    logic                          load_out;
    logic                          ram_re;
    logic [hmf_pkg::IDX_W-1:0]     ram_raddr;
    logic [hmf_pkg::CNT_W-1:0]     ram_rdata;
    hmf_pkg::t_bin_wr              bin_wr;
    logic [hmf_pkg::CNT_W-1:0]     cnt_old;
    logic [hmf_pkg::CNT_W-1:0]     cnt_new;

    assign o_in_stall = (r_state != hmf_pkg::ST_COUNT);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_label_value} < hmf_pkg::BIN_LIM);

    // Forward the count written at the last edge; the memory read missed it
    assign cnt_old = (r_wr_vld && (r_wr_lbl == r_s1_lbl)) ? r_wr_cnt : ram_rdata;
    assign cnt_new = (cnt_old == hmf_pkg::COUNT_MAX) ? cnt_old
                                                     : cnt_old + hmf_pkg::CNT_W'(1);

    // Sequencer and memory port steering
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        load_out    = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;
        bin_wr.we   = 1'b0;
        bin_wr.addr = r_idx;
        bin_wr.data = '0;

        // Count write-back and scan zero write never fall in the same cycle
        if (r_s1_vld) begin
            bin_wr.we   = 1'b1;
            bin_wr.addr = r_s1_lbl;
            bin_wr.data = cnt_new;
        end else if (r_sc_vld) begin
            bin_wr.we   = 1'b1;
            bin_wr.addr = r_sc_idx;
        end

        unique case (r_state)
            hmf_pkg::ST_CLEAR: begin
                bin_wr.we   = 1'b1;
                bin_wr.addr = r_idx;
                bin_wr.data = '0;
                if (r_idx == hmf_pkg::LAST_BIN) begin
                    n_idx   = '0;
                    n_state = hmf_pkg::ST_COUNT;
                end else begin
                    n_idx = r_idx + hmf_pkg::IDX_W'(1);
                end
            end
            hmf_pkg::ST_COUNT: begin
                ram_re    = in_acc;
                ram_raddr = i_label_value[hmf_pkg::IDX_W-1:0];
                if (in_acc && i_last_of_region) begin
                    n_state = hmf_pkg::ST_DRAIN;
                end
            end
            hmf_pkg::ST_DRAIN: begin
                n_idx   = '0;
                n_state = hmf_pkg::ST_SCAN;
            end
            hmf_pkg::ST_SCAN: begin
                ram_re = 1'b1;
                if (r_idx == hmf_pkg::LAST_BIN) begin
                    n_idx   = '0;
                    n_state = hmf_pkg::ST_FINISH;
                end else begin
                    n_idx = r_idx + hmf_pkg::IDX_W'(1);
                end
            end
            hmf_pkg::ST_FINISH: begin
                if (!r_sc_vld && (!r_out_vld || !i_out_stall)) begin
                    load_out = 1'b1;
                    n_state  = hmf_pkg::ST_COUNT;
                end
            end
            default: begin
                n_state = hmf_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hmf_pkg::ST_CLEAR;
            r_idx     <= '0;
            r_s1_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_sc_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_s1_vld  <= in_acc && in_range;
            r_wr_vld  <= r_s1_vld;
            r_sc_vld  <= (r_state == hmf_pkg::ST_SCAN);
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s1_lbl <= i_label_value[hmf_pkg::IDX_W-1:0];
        r_wr_lbl <= r_s1_lbl;
        r_wr_cnt <= cnt_new;
        r_sc_idx <= r_idx;
        // Running maximum; strict compare keeps the lowest label on ties
        if (r_state == hmf_pkg::ST_DRAIN) begin
            r_best_cnt <= '0;
            r_best_lbl <= '0;
        end else if (r_sc_vld && (ram_rdata > r_best_cnt)) begin
            r_best_cnt <= ram_rdata;
            r_best_lbl <= r_sc_idx;
        end
        if (load_out) begin
            r_mode <= hmf_pkg::LBL_W'(r_best_lbl);
        end
    end

    hmf_ram #(
        .WIDTH (hmf_pkg::CNT_W),
        .DEPTH (hmf_pkg::NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (bin_wr.we),
        .i_waddr (bin_wr.addr),
        .i_wdata (bin_wr.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_vld;
    assign o_mode_value = r_mode;

    // Count write-back and scan clearing never compete for the write port
    a_wr_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_vld && r_sc_vld))
        else $error("count and scan writes collide");

    // The last word of a region is drained before the scan reads any bin
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_of_region) |=> (r_state == hmf_pkg::ST_DRAIN))
        else $error("region end did not enter drain");

    // No count write-back is pending while the scan reads
    a_scan_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hmf_pkg::ST_SCAN) |-> !r_s1_vld)
        else $error("scan started with counts in flight");

    // A new result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_vld || !i_out_stall))
        else $error("result overwritten");

endmodule

FILE: bench/histogram_mode_finder_tb.sv
`timescale 1ns / 1ps

module histogram_mode_finder_tb;

    // Run limits
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SCAN_CYCLES = hmf_pkg::NUM_BINS + 8;

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_in_valid       = 1'b0;
    logic                      o_in_stall;
    logic [hmf_pkg::LBL_W-1:0] i_label_value    = '0;
    logic                      i_last_of_region = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall      = 1'b0;
    logic [hmf_pkg::LBL_W-1:0] o_mode_value;

    // Histogram mirror and the modes still owed by the block
    logic [hmf_pkg::CNT_W-1:0] bin_count [hmf_pkg::NUM_BINS];
    logic [hmf_pkg::LBL_W-1:0] mode_q [$];
    logic [hmf_pkg::LBL_W-1:0] want_mode;

    int fail_count  = 0;
    int cycle_count = 0;
    int hold_req    = 0;
    bit idle_on     = 1'b1;

    histogram_mode_finder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_label_value    (i_label_value),
        .i_last_of_region (i_last_of_region),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mode_value     (o_mode_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Count one accepted pixel; on the last one, scan for the mode and clear
    task automatic count_label(input logic [hmf_pkg::LBL_W-1:0] label, input logic last);
        logic [hmf_pkg::CNT_W-1:0] best_cnt;
        logic [hmf_pkg::LBL_W-1:0] best_lbl;
        best_cnt = '0;
        best_lbl = '0;
        if (int'(label) < hmf_pkg::NUM_BINS && bin_count[int'(label)] != hmf_pkg::COUNT_MAX)
            bin_count[int'(label)]++;
        if (last) begin
            // strict compare keeps the lowest label on ties
            for (int b = 0; b < hmf_pkg::NUM_BINS; b++) begin
                if (bin_count[b] > best_cnt) begin
                    best_cnt = bin_count[b];
                    best_lbl = hmf_pkg::LBL_W'(b);
                end
            end
            mode_q = {mode_q, best_lbl};
            for (int b = 0; b < hmf_pkg::NUM_BINS; b++)
                bin_count[b] = '0;
        end
    endtask

    // Offer one word, with an optional idle burst first; returns at the accepting edge
    task automatic send_word(input logic [hmf_pkg::LBL_W-1:0] label, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_label_value    <= label;
        i_last_of_region <= last;
        do @(posedge i_clk); while (o_in_stall);
        count_label(label, last);
    endtask

    task automatic send_run(input logic [hmf_pkg::LBL_W-1:0] label, input int n,
                            input logic last);
        for (int k = 0; k < n; k++)
            send_word(label, last && (k == n - 1));
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (mode_q.size() != 0) @(posedge i_clk);
    endtask

    // Output stall driver: random bursts plus a requested long hold-off
    initial begin : out_stall_drive
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mode_q.size() == 0) begin
                $error("unexpected result word: mode_value actual %0d", o_mode_value);
                fail_count++;
            end else begin
                want_mode = mode_q.pop_front();
                if (o_mode_value !== want_mode) begin
                    $error("mode_value mismatch: expected %0d, actual %0d",
                           want_mode, o_mode_value);
                    fail_count++;
                end
            end
        end
    end

    // One-pixel regions at the label extremes and alternating bit patterns
    task automatic test_single_pixel_regions();
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h55, 1'b1);
        send_word(8'hAA, 1'b1);
    endtask

    // Ties go to the lowest label; a clear majority wins wherever it sits
    task automatic test_tie_breaks();
        send_word(8'd5, 1'b0);
        send_word(8'd3, 1'b0);
        send_word(8'd5, 1'b0);
        send_word(8'd3, 1'b1);
        send_word(8'd200, 1'b0);
        send_word(8'd7, 1'b1);
        send_word(8'd9, 1'b0);
        send_word(8'd9, 1'b0);
        send_word(8'd1, 1'b1);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd255, 1'b1);
    endtask

    // Two long back-to-back runs in one region; the later label has one
    // more pixel and takes the mode
    task automatic test_long_region();
        idle_on = 1'b0;
        send_run(8'd16, 200, 1'b0);
        send_run(8'd200, 201, 1'b1);
        idle_on = 1'b1;
    endtask

    // Receiver holds off long enough that finished results back up into the input
    task automatic test_output_hold_off();
        hold_req = 3 * SCAN_CYCLES;
        for (int r = 0; r < 6; r++) begin
            send_word(hmf_pkg::LBL_W'($urandom), 1'b0);
            send_word(hmf_pkg::LBL_W'($urandom_range(0, 3)), 1'b1);
        end
    endtask

    // Sender stops until everything owed has come out, then resumes
    task automatic test_pause_for_results();
        send_word(8'd77, 1'b0);
        send_word(8'd78, 1'b1);
        wait_results_done();
        send_word(8'd78, 1'b1);
    endtask

    // Regions of random length; most draw from a narrow label band to force
    // close races and ties, the rest are fully random labels
    task automatic test_random_regions(input int n_words);
        int                        sent;
        int                        len;
        int                        kind;
        logic [hmf_pkg::LBL_W-1:0] base;
        logic [hmf_pkg::LBL_W-1:0] lbl;
        sent = 0;
        while (sent < n_words) begin
            kind = $urandom_range(0, 9);
            len  = (kind == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
            base = hmf_pkg::LBL_W'($urandom);
            for (int k = 0; k < len; k++) begin
                if (kind < 7)
                    lbl = base + hmf_pkg::LBL_W'($urandom_range(0, 3));
                else
                    lbl = hmf_pkg::LBL_W'($urandom);
                send_word(lbl, k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        for (int b = 0; b < hmf_pkg::NUM_BINS; b++)
            bin_count[b] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_pixel_regions();
        test_tie_breaks();
        test_long_region();
        test_output_hold_off();
        test_pause_for_results();
        test_random_regions(600);
        test_pause_for_results();
        test_random_regions(450);
        // final stretch with no idling on either side
        idle_on = 1'b0;
        test_random_regions(300);

        wait_results_done();
        repeat (SCAN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && mode_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hmf_pkg.sv
rtl/hmf_ram.sv
rtl/histogram_mode_finder.sv
bench/histogram_mode_finder_tb.sv
